// ----- rtl/core/mpso_pkg.sv -----
package mpso_pkg;

	localparam int DEFAULT_PIXEL_BITS = 8;
	localparam int SPRITE_ROWS        = 16;
	localparam int SHAPE_COUNT        = 4;
	localparam int WIDEST_SPRITE      = 24;

	// raw coordinate space and scaling constants
	localparam int RAW_WIDTH     = 1280;
	localparam int RAW_HEIGHT    = 1024;
	localparam int LEFT_MAX      = 65535;
	localparam int LEFT_MIN_MAG  = 65536;
	localparam int TOP_MAX       = 4095;
	// divide by five: floor(q * RECIP5 / 2**RECIP5_SHIFT) is exact for q < 2**19
	localparam logic [18:0] RECIP5       = 19'd419431;
	localparam int          RECIP5_SHIFT = 21;

	// reset values of the configuration registers
	localparam logic [2:0]  RESET_MODE   = 3'd0;
	localparam logic [11:0] RESET_WIDTH  = 12'd640;
	localparam logic [10:0] RESET_HEIGHT = 11'd256;

	// modes with pointer artwork
	localparam logic [2:0] MODE_LAST_ART = 3'd2;

	typedef enum logic [2:0] {
		CFG_MODE   = 3'd0,
		CFG_WIDTH  = 3'd1,
		CFG_HEIGHT = 3'd2,
		CFG_BODY   = 3'd3,
		CFG_HALO   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ART_CLEAR,
		ART_BODY,
		ART_HALO
	} art_t;

	typedef struct packed {
		logic               shown;
		logic signed [16:0] left;
		logic [11:0]        top;
		logic [1:0]         mode;
		logic [1:0]         kind;
	} ptr_state_t;

	localparam logic [7:0] CH_BODY = "#";
	localparam logic [7:0] CH_HALO = "o";

	localparam logic [191:0] ART24 [4][16] = '{
		'{"......oooooooooo........", "......oo######oo........", "......oo######oo........",
		  "......oo######oo........", "......oo######oo........", "oooooooo######oooooooo..",
		  "oo##################oo..", "oo##################oo..", "oo##################oo..",
		  "oooooooo######oooooooo..", "......oo######oo........", "......oo######oo........",
		  "......oo######oo........", "......oo######oo........", "......oooooooooo........",
		  "........................"},
		'{"..........oooooo........", "......oooo######oooo....", "....oo##############oo..",
		  "....oo####oooooo####oo..", "..oo####oo......oo####oo", "..oo####oo......oo####oo",
		  "..oo####oo......oo####oo", "....oo####oooooo####oo..", "....oo##############oo..",
		  "......oooo########oo....", "..........oooo####oo....", "............oooo####oo..",
		  "..............oo####oo..", "................oo####oo", "................oo####oo",
		  "..................oooo.."},
		'{"oooo....................", "oo##oo..................", "oo####oo................",
		  "oo######oo..............", "oo########oo............", "oo##########oo..........",
		  "oo############oo........", "oo########oooo..........", "oo##oo####oo............",
		  "oooooooo####oo..........", "......oo####oo..........", "........oo####oo........",
		  "........oo####oo........", "..........oo####oo......", "..........oo####oo......",
		  "............oooo........"},
		'{"....................oooo", "..................oo##oo", "................oo####oo",
		  "..............oo######oo", "............oo########oo", "..........oo##########oo",
		  "........oo############oo", "..........oooo########oo", "............oo####oo##oo",
		  "..........oo####oooooooo", "..........oo####oo......", "........oo####oo........",
		  "........oo####oo........", "......oo####oo..........", "......oo####oo..........",
		  "........oooo............"}
	};

	localparam logic [95:0] ART12 [4][16] = '{
		'{"...ooooo....", "...o###o....", "...o###o....", "...o###o....", "...o###o....",
		  "oooo###oooo.", "o#########o.", "o#########o.", "o#########o.", "oooo###oooo.",
		  "...o###o....", "...o###o....", "...o###o....", "...o###o....", "...ooooo....",
		  "............"},
		'{".....ooo....", "...oo###oo..", "..o#######o.", "..o##ooo##o.", ".o##o...o##o",
		  ".o##o...o##o", ".o##o...o##o", "..o##ooo##o.", "..o#######o.", "...oo####o..",
		  "....ooo##o..", ".......o##o.", ".......o##o.", "........o##o", "........o##o",
		  ".........oo."},
		'{"oo..........", "o#o.........", "o##o........", "o###o.......", "o####o......",
		  "o#####o.....", "o######o....", "o####oo.....", "o#o##o......", "oooo##o.....",
		  "...o##o.....", "....o##o....", "....o##o....", ".....o##o...", ".....o##o...",
		  "......oo...."},
		'{"..........oo", ".........o#o", "........o##o", ".......o###o", "......o####o",
		  ".....o#####o", "....o######o", "......o####o", "......o##o#o", ".....o##oooo",
		  ".....o##o...", "....o##o....", "....o##o....", "...o##o.....", "...o##o.....",
		  "....oo......"}
	};

	localparam logic [47:0] ART6 [4][16] = '{
		'{"..ooo.", "..o#o.", "..o#o.", "..o#o.", "..o#o.", "..o#o.", ".o###o", ".o###o",
		  ".o###o", "..o#o.", "..o#o.", "..o#o.", "..o#o.", "..o#o.", "..ooo.", "......"},
		'{"..oo..", ".o##o.", ".o##o.", "o#oo#o", "o#oo#o", "o#oo#o", "o#oo#o", "o#oo#o",
		  ".o##o.", ".o##o.", "..o#o.", "...o#o", "...o#o", "...o#o", "...o#o", "....o."},
		'{"oo....", "o#o...", "o#o...", "o##o..", "o##o..", "o###o.", "o###o.", "o##o..",
		  "o##o..", "ooo#o.", "..o#o.", "..o#o.", "..o#o.", "...o#o", "...o#o", "....o."},
		'{"....oo", "...o#o", "...o#o", "..o##o", "..o##o", ".o###o", ".o###o", "..o##o",
		  "..o##o", ".o#ooo", ".o#o..", ".o#o..", ".o#o..", "o#o...", "o#o...", ".o...."}
	};

	// artwork cell of one shape; col must be inside the shape width
	function automatic art_t art_lookup(input logic [1:0] mode, input logic [1:0] kind,
			input logic [3:0] row, input logic [4:0] col);
		logic [4:0] r24;
		logic [3:0] r12;
		logic [2:0] r6;
		logic [7:0] ch;
		art_t       code;
		r24 = 5'd23 - col;
		r12 = 4'd11 - col[3:0];
		r6  = 3'd5 - col[2:0];
		case (mode)
			2'd0:    ch = ART24[kind][row][{r24, 3'b000} +: 8];
			2'd1:    ch = ART12[kind][row][{r12, 3'b000} +: 8];
			2'd2:    ch = ART6[kind][row][{r6, 3'b000} +: 8];
			default: ch = 8'h2E;
		endcase
		if (ch == CH_BODY) begin
			code = ART_BODY;
		end else if (ch == CH_HALO) begin
			code = ART_HALO;
		end else begin
			code = ART_CLEAR;
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/mpso_hit.sv -----
module mpso_hit (
	input  mpso_pkg::ptr_state_t st,
	input  logic [10:0]          px,
	input  logic [9:0]           py,
	input  logic [11:0]          width,
	input  logic [10:0]          height,
	output mpso_pkg::art_t       code
);

	logic signed [12:0] row;
	logic signed [17:0] col;
	logic [4:0]         shape_w;
	logic               on_screen;
	logic               row_ok;
	logic               col_ok;

	// sprite rows count toward smaller pixel_y from the top row
	assign row = $signed({1'b0, st.top}) - $signed({3'b000, py});
	assign col = $signed({7'b0, px}) - $signed({st.left[16], st.left});

	// shape width by artwork set
	always_comb begin
		case (st.mode)
			2'd0:    shape_w = 5'd24;
			2'd1:    shape_w = 5'd12;
			2'd2:    shape_w = 5'd6;
			default: shape_w = 5'd0;
		endcase
	end

	assign on_screen = ({1'b0, px} < width) && ({1'b0, py} < height);
	assign row_ok    = (row[12:4] == 9'd0);
	assign col_ok    = (col[17:5] == 13'd0) && (col[4:0] < shape_w);

	assign code = (st.shown && on_screen && row_ok && col_ok)
		? mpso_pkg::art_lookup(st.mode, st.kind, row[3:0], col[4:0])
		: mpso_pkg::ART_CLEAR;

endmodule

// ----- rtl/core/mouse_pointer_sprite_overlay_unit.sv -----
// channel | direction | handshake             | payload
// in      | sink      | in_valid / in_ready   | command, mouse_x_raw, mouse_y_raw, pointer_type,
//         |           |                       | pixel_x, pixel_y, pixel_in
// out     | source    | out_valid / out_ready | pixel_out, pointer_hit (pixel transactions only)
// cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// one transaction per clock unless stalled; a pixel result is registered in turn through
// the input register, product register and result register
// position transactions update the pointer state at the product stage, in order with pixels
// the whole pipeline advances while the result register is empty or being taken
// reset clears control and configuration to their defaults, pointer hidden
module mouse_pointer_sprite_overlay_unit #(
	parameter  int PIXEL_BITS = mpso_pkg::DEFAULT_PIXEL_BITS,
	localparam int CFG_BITS   = (PIXEL_BITS > 12) ? PIXEL_BITS : 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic signed [15:0]    mouse_x_raw,
	input  logic [11:0]           mouse_y_raw,
	input  logic [3:0]            pointer_type,
	input  logic [10:0]           pixel_x,
	input  logic [9:0]            pixel_y,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic                  pointer_hit,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data
);

	logic [2:0]            mode_q;
	logic [11:0]           width_q;
	logic [10:0]           height_q;
	logic [PIXEL_BITS-1:0] body_q;
	logic [PIXEL_BITS-1:0] halo_q;
	mpso_pkg::ptr_state_t  st_q;

	logic                  en;
	logic                  v_s1, v_s2, out_valid_q;
	logic                  cmd_s1, cmd_s2;
	logic signed [15:0]    x_s1;
	logic [11:0]           y_s1;
	logic [3:0]            type_s1;
	logic [10:0]           px_s1, px_s2;
	logic [9:0]            py_s1, py_s2;
	logic [PIXEL_BITS-1:0] pin_s1, pin_s2;
	logic                  neg_s2, hide_s2;
	logic [1:0]            kind_s2;
	logic [27:0]           prodx_s2;
	logic [22:0]           prody_s2;
	logic [PIXEL_BITS-1:0] pixel_out_q;
	logic                  hit_q;

	logic [15:0]           x_abs;
	logic [37:0]           quot_full;
	logic [16:0]           quot;
	logic [16:0]           mag;
	logic signed [16:0]    left_new;
	logic [12:0]           top_full;
	logic [11:0]           top_new;
	mpso_pkg::art_t        code;
	logic                  cfg_wr;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mpso_pkg::RESET_MODE;
			width_q  <= mpso_pkg::RESET_WIDTH;
			height_q <= mpso_pkg::RESET_HEIGHT;
			body_q   <= PIXEL_BITS'(1);
			halo_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				mpso_pkg::CFG_MODE:   mode_q   <= cfg_data[2:0];
				mpso_pkg::CFG_WIDTH:  width_q  <= cfg_data[11:0];
				mpso_pkg::CFG_HEIGHT: height_q <= cfg_data[10:0];
				mpso_pkg::CFG_BODY:   body_q   <= cfg_data[PIXEL_BITS-1:0];
				mpso_pkg::CFG_HALO:   halo_q   <= cfg_data[PIXEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			cmd_s1  <= command;
			x_s1    <= mouse_x_raw;
			y_s1    <= mouse_y_raw;
			type_s1 <= pointer_type;
			px_s1   <= pixel_x;
			py_s1   <= pixel_y;
			pin_s1  <= pixel_in;
		end
	end

	// product stage: magnitude of x times width, y times height
	assign x_abs = x_s1[15] ? 16'(-x_s1) : 16'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			cmd_s2   <= cmd_s1;
			neg_s2   <= x_s1[15];
			hide_s2  <= (type_s1 >= 4'(mpso_pkg::SHAPE_COUNT))
				|| (mode_q > mpso_pkg::MODE_LAST_ART);
			kind_s2  <= type_s1[1:0];
			prodx_s2 <= 28'(x_abs) * 28'(width_q);
			prody_s2 <= 23'(y_s1) * 23'(height_q);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			pin_s2   <= pin_s1;
		end
	end

	// divide by 1280: shift by 256, then reciprocal multiply by 1/5
	assign quot_full = 38'(prodx_s2[26:8]) * 38'(mpso_pkg::RECIP5);
	assign quot      = quot_full[mpso_pkg::RECIP5_SHIFT +: 17];
	always_comb begin
		if (neg_s2) begin
			mag = (quot > 17'(mpso_pkg::LEFT_MIN_MAG)) ? 17'(mpso_pkg::LEFT_MIN_MAG) : quot;
			left_new = -$signed(mag);
		end else begin
			mag = (quot > 17'(mpso_pkg::LEFT_MAX)) ? 17'(mpso_pkg::LEFT_MAX) : quot;
			left_new = $signed(mag);
		end
	end

	// divide by 1024 truncates, then clamp to the row range
	assign top_full = prody_s2[22:10];
	assign top_new  = (top_full > 13'(mpso_pkg::TOP_MAX)) ? 12'(mpso_pkg::TOP_MAX)
		: top_full[11:0];

	// pointer state: position transactions and mode writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (cfg_wr && (cfg_index == mpso_pkg::CFG_MODE)) begin
			st_q.shown <= 1'b0;
		end else if (en && v_s2 && !cmd_s2) begin
			if (hide_s2) begin
				st_q.shown <= 1'b0;
			end else begin
				st_q.shown <= 1'b1;
				st_q.left  <= left_new;
				st_q.top   <= top_new;
				st_q.mode  <= mode_q[1:0];
				st_q.kind  <= kind_s2;
			end
		end
	end

	mpso_hit u_hit (
		.st     (st_q),
		.px     (px_s2),
		.py     (py_s2),
		.width  (width_q),
		.height (height_q),
		.code   (code)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s2 && cmd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2 && cmd_s2) begin
			unique case (code)
				mpso_pkg::ART_BODY: begin
					pixel_out_q <= body_q;
					hit_q       <= 1'b1;
				end
				mpso_pkg::ART_HALO: begin
					pixel_out_q <= halo_q;
					hit_q       <= 1'b1;
				end
				default: begin
					pixel_out_q <= pin_s2;
					hit_q       <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign pointer_hit = hit_q;

	// a hit always carries one of the two pointer colours
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_q |-> (pixel_out_q == body_q) || (pixel_out_q == halo_q))
		else $error("pointer hit with a colour other than body or halo");

	// a mode write hides the pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (cfg_index == mpso_pkg::CFG_MODE) |=> !st_q.shown)
		else $error("pointer still shown after mode write");

	// a new result only comes from a pixel transaction at the product stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s2 && cmd_s2))
		else $error("result without a pixel transaction");

endmodule

// ----- verif/mpso_checker.sv -----
module mpso_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               command,
	input  logic signed [15:0] mouse_x_raw,
	input  logic [11:0]        mouse_y_raw,
	input  logic [3:0]         pointer_type,
	input  logic [10:0]        pixel_x,
	input  logic [9:0]         pixel_y,
	input  logic [7:0]         pixel_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         pixel_out,
	input  logic               pointer_hit,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic [7:0] pix;
		logic       hit;
	} overlay_t;

	overlay_t expected_pixels[$];

	// register copies
	logic [2:0]  mode_reg;
	logic [11:0] width_reg;
	logic [10:0] height_reg;
	logic [7:0]  body_reg;
	logic [7:0]  halo_reg;

	// latched pointer
	longint      ptr_left;
	longint      ptr_top;
	logic [1:0]  ptr_mode;
	logic [1:0]  ptr_kind;
	bit          ptr_shown;

	// artwork cell at sprite row and column, clear outside the shape
	function automatic mpso_pkg::art_t sprite_cell(input logic [1:0] m, input logic [1:0] k,
			input longint row, input longint col);
		int         w;
		logic [7:0] ch;
		w = (m == 2'd0) ? 24 : (m == 2'd1) ? 12 : 6;
		if (m > 2'd2 || row < 0 || row >= mpso_pkg::SPRITE_ROWS || col < 0 || col >= w)
			return mpso_pkg::ART_CLEAR;
		case (m)
			2'd0:    ch = mpso_pkg::ART24[k][row][(23 - col) * 8 +: 8];
			2'd1:    ch = mpso_pkg::ART12[k][row][(11 - col) * 8 +: 8];
			default: ch = mpso_pkg::ART6[k][row][(5 - col) * 8 +: 8];
		endcase
		if (ch == mpso_pkg::CH_BODY) return mpso_pkg::ART_BODY;
		if (ch == mpso_pkg::CH_HALO) return mpso_pkg::ART_HALO;
		return mpso_pkg::ART_CLEAR;
	endfunction

	// overlay result for one pixel transaction
	function automatic overlay_t overlay_pixel(input logic [10:0] px, input logic [9:0] py,
			input logic [7:0] pin);
		overlay_t       r;
		mpso_pkg::art_t c;
		r.pix = pin;
		r.hit = 1'b0;
		if (ptr_shown && px < width_reg && py < height_reg) begin
			c = sprite_cell(ptr_mode, ptr_kind, ptr_top - longint'(py), longint'(px) - ptr_left);
			if (c == mpso_pkg::ART_BODY) begin
				r.pix = body_reg;
				r.hit = 1'b1;
			end else if (c == mpso_pkg::ART_HALO) begin
				r.pix = halo_reg;
				r.hit = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint   lx;
		longint   ty;
		overlay_t want;
		if (!arst_n) begin
			mode_reg   = mpso_pkg::RESET_MODE;
			width_reg  = mpso_pkg::RESET_WIDTH;
			height_reg = mpso_pkg::RESET_HEIGHT;
			body_reg   = 8'd1;
			halo_reg   = 8'd0;
			ptr_left   = 0;
			ptr_top    = 0;
			ptr_mode   = 2'd0;
			ptr_kind   = 2'd0;
			ptr_shown  = 0;
			errors     = 0;
			expected_pixels.delete();
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (mpso_pkg::cfg_idx_t'(cfg_index))
					mpso_pkg::CFG_MODE: begin
						mode_reg  = cfg_data[2:0];
						ptr_shown = 0;
					end
					mpso_pkg::CFG_WIDTH:  width_reg  = cfg_data[11:0];
					mpso_pkg::CFG_HEIGHT: height_reg = cfg_data[10:0];
					mpso_pkg::CFG_BODY:   body_reg   = cfg_data[7:0];
					mpso_pkg::CFG_HALO:   halo_reg   = cfg_data[7:0];
					default: ;
				endcase
			end
			// compare the result taken at this edge
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result pixel=%0d hit=%0d", pixel_out, pointer_hit);
				end else begin
					want = expected_pixels.pop_front();
					if (want.pix !== pixel_out || want.hit !== pointer_hit) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected pixel=%0d hit=%0d, got pixel=%0d hit=%0d",
								want.pix, want.hit, pixel_out, pointer_hit);
					end
				end
			end
			// predict from the accepted input transaction
			if (in_valid && in_ready) begin
				if (command == 1'b0) begin
					if (pointer_type >= mpso_pkg::SHAPE_COUNT
						|| mode_reg > mpso_pkg::MODE_LAST_ART) begin
						ptr_shown = 0;
					end else begin
						lx = longint'(mouse_x_raw) * longint'(width_reg) / mpso_pkg::RAW_WIDTH;
						ty = longint'(mouse_y_raw) * longint'(height_reg) / mpso_pkg::RAW_HEIGHT;
						if (lx > mpso_pkg::LEFT_MAX) lx = mpso_pkg::LEFT_MAX;
						if (lx < -mpso_pkg::LEFT_MIN_MAG) lx = -mpso_pkg::LEFT_MIN_MAG;
						if (ty > mpso_pkg::TOP_MAX) ty = mpso_pkg::TOP_MAX;
						ptr_left  = lx;
						ptr_top   = ty;
						ptr_mode  = mode_reg[1:0];
						ptr_kind  = pointer_type[1:0];
						ptr_shown = 1;
					end
				end else begin
					expected_pixels.push_back(overlay_pixel(pixel_x, pixel_y, pixel_in));
				end
			end
		end
		pending = expected_pixels.size();
	end

endmodule

// ----- verif/testbench.sv -----
module testbench;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic signed [15:0] mouse_x_raw;
	logic [11:0]        mouse_y_raw;
	logic [3:0]         pointer_type;
	logic [10:0]        pixel_x;
	logic [9:0]         pixel_y;
	logic [7:0]         pixel_in;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         pixel_out;
	logic               pointer_hit;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [11:0]        cfg_data;

	int errors;
	int pending;

	// sink control and current screen size for aiming pixels
	bit quiet;
	bit hold_req;
	int cur_w;
	int cur_h;

	mouse_pointer_sprite_overlay_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.mouse_x_raw(mouse_x_raw), .mouse_y_raw(mouse_y_raw), .pointer_type(pointer_type),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .pointer_hit(pointer_hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mpso_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.mouse_x_raw(mouse_x_raw), .mouse_y_raw(mouse_y_raw), .pointer_type(pointer_type),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_out(pixel_out), .pointer_hit(pointer_hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink: random stalls, long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// offer one input transaction and wait until it is taken
	task automatic offer(input logic cmd, input logic [15:0] x, input logic [11:0] y,
			input logic [3:0] kind, input logic [10:0] px, input logic [9:0] py,
			input logic [7:0] pin);
		in_valid     <= 1'b1;
		command      <= cmd;
		mouse_x_raw  <= x;
		mouse_y_raw  <= y;
		pointer_type <= kind;
		pixel_x      <= px;
		pixel_y      <= py;
		pixel_in     <= pin;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic place(input logic [15:0] x, input logic [11:0] y, input logic [3:0] kind);
		offer(1'b0, x, y, kind, 11'($urandom), 10'($urandom), 8'($urandom));
	endtask

	task automatic paint(input logic [10:0] px, input logic [9:0] py, input logic [7:0] pin);
		offer(1'b1, 16'($urandom), 12'($urandom), 4'($urandom), px, py, pin);
	endtask

	// wait until every result is back, then for the pipeline to drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input mpso_pkg::cfg_idx_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 12'(val);
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == mpso_pkg::CFG_WIDTH) cur_w = val & 12'hFFF;
		if (idx == mpso_pkg::CFG_HEIGHT) cur_h = val & 11'h7FF;
	endtask

	task automatic set_screen(input int mode, input int w, input int h, input int body,
			input int halo);
		drain();
		write_reg(mpso_pkg::CFG_WIDTH, w);
		write_reg(mpso_pkg::CFG_HEIGHT, h);
		write_reg(mpso_pkg::CFG_BODY, body);
		write_reg(mpso_pkg::CFG_HALO, halo);
		write_reg(mpso_pkg::CFG_MODE, mode);
	endtask

	// pointer placed, mostly on screen, then pixels aimed at its box plus some noise
	task automatic pointer_burst(input int npix);
		int          x;
		int          y;
		int          tx;
		int          ty;
		logic [3:0]  kind;
		x    = ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom))) : $urandom_range(0, 1279);
		y    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1023);
		kind = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 3));
		place(16'(x), 12'(y), kind);
		tx = x * cur_w / 1280;
		ty = y * cur_h / 1024;
		repeat (npix) begin
			if ($urandom_range(0, 7) == 0)
				paint(11'($urandom), 10'($urandom), 8'($urandom));
			else
				paint(11'(tx + $urandom_range(0, 27) - 2), 10'(ty - $urandom_range(0, 19) + 2),
					8'($urandom));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = 1'b0;
		mouse_x_raw  = '0;
		mouse_y_raw  = '0;
		pointer_type = '0;
		pixel_x      = '0;
		pixel_y      = '0;
		pixel_in     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = mpso_pkg::CFG_MODE;
		cfg_data     = '0;
		quiet        = 0;
		hold_req     = 0;
		cur_w        = mpso_pkg::RESET_WIDTH;
		cur_h        = mpso_pkg::RESET_HEIGHT;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: hidden after reset, shapes, hiding types, field extremes
		paint(11'd0, 10'd0, 8'd255);
		place(16'd0, 12'd1023, 4'd0);
		paint(11'd6, 10'd255, 8'd0);
		paint(11'd8, 10'd254, 8'd77);
		paint(11'd0, 10'd255, 8'd3);
		paint(11'd2047, 10'd1023, 8'd255);
		place(16'd40, 12'd800, 4'd1);
		paint(11'd30, 10'd196, 8'hAA);
		place(16'd1279, 12'd4095, 4'd2);
		paint(11'd639, 10'd255, 8'h55);
		place(16'sh8000, 12'd0, 4'd3);
		paint(11'd0, 10'd0, 8'd1);
		place(16'sh7FFF, 12'd100, 4'd3);
		paint(11'd639, 10'd20, 8'd9);
		place(16'd100, 12'd500, 4'd4);
		paint(11'd50, 10'd125, 8'd12);
		place(16'd100, 12'd500, 4'd15);
		paint(11'd51, 10'd124, 8'd13);
		place(16'd200, 12'd512, 4'd2);
		paint(11'd100, 10'd128, 8'd14);
		paint(11'd101, 10'd127, 8'd15);

		// random phases across register settings
		set_screen(0, 640, 256, 1, 0);
		repeat (5) pointer_burst(12);
		set_screen(1, 2048, 1024, 255, 0);
		repeat (5) pointer_burst(12);
		// long receiver hold-off while the sender keeps offering
		hold_req = 1;
		repeat (3) pointer_burst(15);
		set_screen(2, 1, 1, 0, 255);
		repeat (3) pointer_burst(8);
		set_screen(2, 1280, 1024, 170, 85);
		repeat (5) pointer_burst(12);
		// sender pause until everything is back
		drain();
		repeat (2) pointer_burst(10);
		set_screen(0, 4095, 2047, 33, 204);
		repeat (4) pointer_burst(12);
		set_screen(0, 0, 0, 7, 8);
		repeat (2) pointer_burst(6);
		set_screen(3, 640, 256, 1, 0);
		repeat (2) pointer_burst(6);
		set_screen(7, 800, 600, 2, 3);
		repeat (2) pointer_burst(6);
		set_screen(1, 1024, 768, 240, 15);
		repeat (4) pointer_burst(12);
		// final stretch without idling
		quiet = 1;
		set_screen(0, 2048, 512, 99, 200);
		repeat (5) pointer_burst(12);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- mouse_pointer_sprite_overlay_unit.f -----
rtl/core/mpso_pkg.sv
rtl/core/mpso_hit.sv
rtl/core/mouse_pointer_sprite_overlay_unit.sv
verif/mpso_checker.sv
verif/testbench.sv
